FILE: design/uks_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uks_pkg
// Shared types and codes for the unique-key stack: command and status codes
// and the key/data pair held in the store.
// ----------------------------------------------------------------------------
package uks_pkg;

	localparam int unsigned KEY_W   = 32;
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 5;

	typedef logic [1:0] cmd_t;
	typedef logic [1:0] status_t;

	localparam cmd_t CMD_PUSH = 2'd0;
	localparam cmd_t CMD_POP  = 2'd1;
	localparam cmd_t CMD_PEEK = 2'd2;

	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_DUP   = 2'd1;
	localparam status_t ST_FULL  = 2'd2;
	localparam status_t ST_EMPTY = 2'd3;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} entry_t;

endpackage
`default_nettype wire

FILE: design/uks_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uks_req_if
// Command channel: valid/ready handshake carrying one push, pop or peek.
// ----------------------------------------------------------------------------
interface uks_req_if;
	logic                                valid;
	logic                                ready;
	uks_pkg::cmd_t                       cmd;
	logic signed [uks_pkg::KEY_W-1:0]    push_key;
	logic signed [uks_pkg::VALUE_W-1:0]  push_value;

	modport source (output valid, output cmd, output push_key, output push_value,
		input ready);
	modport sink (input valid, input cmd, input push_key, input push_value,
		output ready);
endinterface
`default_nettype wire

FILE: design/uks_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uks_rsp_if
// Response channel: valid/ready handshake carrying one result beat.
// ----------------------------------------------------------------------------
interface uks_rsp_if;
	logic                                valid;
	logic                                ready;
	uks_pkg::status_t                    status;
	logic signed [uks_pkg::KEY_W-1:0]    top_key;
	logic signed [uks_pkg::VALUE_W-1:0]  top_value;
	logic [uks_pkg::COUNT_W-1:0]         entry_count;
	logic                                is_empty;

	modport source (output valid, output status, output top_key, output top_value,
		output entry_count, output is_empty, input ready);
	modport sink (input valid, input status, input top_key, input top_value,
		input entry_count, input is_empty, output ready);
endinterface
`default_nettype wire

FILE: design/uks_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uks_store
// Key/data pair memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module uks_store #(
	parameter int unsigned STACK_DEPTH = 16,
	parameter int unsigned ADDR_W      = 4
) (
	input  wire logic                  clk,
	input  wire logic                  wr_en,
	input  wire logic [ADDR_W-1:0]     wr_addr,
	input  wire uks_pkg::entry_t       wr_data,
	input  wire logic [ADDR_W-1:0]     rd_addr,
	output      uks_pkg::entry_t       rd_data
);

	uks_pkg::entry_t mem_q [STACK_DEPTH];
	uks_pkg::entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

FILE: design/uks_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uks_seq
// Command sequencer: walks the store one key per cycle through a single
// comparator for the duplicate check, commits pushes and pops, and holds
// the response register.
// ----------------------------------------------------------------------------
module uks_seq #(
	parameter int unsigned STACK_DEPTH = 16,
	parameter int unsigned ADDR_W      = 4,
	parameter int unsigned CNT_W       = 5
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	uks_req_if.sink                    req,
	uks_rsp_if.source                  rsp,
	output      logic                  mem_wr_en,
	output      logic [ADDR_W-1:0]     mem_wr_addr,
	output      uks_pkg::entry_t       mem_wr_data,
	output      logic [ADDR_W-1:0]     mem_rd_addr,
	input  wire uks_pkg::entry_t       mem_rd_data
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SCAN,
		S_TOP,
		S_DONE
	} state_t;

	state_t                      state_q, state_d;
	logic [CNT_W-1:0]            fill_q, fill_d;
	logic [ADDR_W-1:0]           idx_q, idx_d;
	uks_pkg::cmd_t               cmd_q;
	logic [uks_pkg::KEY_W-1:0]   key_q;
	logic [uks_pkg::VALUE_W-1:0] value_q;
	uks_pkg::status_t            res_status_q, res_status_d;
	uks_pkg::entry_t             res_pair_q, res_pair_d;

	logic                        rsp_valid_q;
	uks_pkg::status_t            rsp_status_q;
	uks_pkg::entry_t             rsp_pair_q;
	logic [uks_pkg::COUNT_W-1:0] rsp_count_q;
	logic                        rsp_empty_q;

	logic                        accept;
	logic                        out_free;
	logic                        is_full;
	logic [CNT_W-1:0]            last_idx;

	assign accept   = req.valid && req.ready;
	assign out_free = !rsp_valid_q || rsp.ready;
	assign is_full  = (fill_q == CNT_W'(STACK_DEPTH));
	assign last_idx = fill_q - 1'b1;

	assign req.ready = (state_q == S_IDLE);

	assign mem_wr_addr = ADDR_W'(fill_q);
	assign mem_wr_data = '{key: key_q, value: value_q};

	always_comb begin
		state_d      = state_q;
		fill_d       = fill_q;
		idx_d        = idx_q;
		res_status_d = res_status_q;
		res_pair_d   = res_pair_q;
		mem_wr_en    = 1'b0;
		mem_rd_addr  = '0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				res_status_d = uks_pkg::ST_OK;
				res_pair_d   = '0;
				idx_d        = '0;
				priority if (cmd_q == uks_pkg::CMD_PUSH) begin
					if (fill_q == '0) begin
						// nothing to search; depth is at least one
						mem_wr_en = 1'b1;
						fill_d    = fill_q + 1'b1;
						state_d   = S_DONE;
					end else begin
						mem_rd_addr = '0;
						state_d     = S_SCAN;
					end
				end else if (cmd_q == uks_pkg::CMD_POP || cmd_q == uks_pkg::CMD_PEEK) begin
					if (fill_q == '0) begin
						res_status_d = uks_pkg::ST_EMPTY;
						state_d      = S_DONE;
					end else begin
						mem_rd_addr = ADDR_W'(last_idx);
						state_d     = S_TOP;
					end
				end else begin
					state_d = S_DONE;
				end
			end
			S_SCAN: begin
				// read data belongs to idx_q, issued last cycle
				priority if (mem_rd_data.key == key_q) begin
					res_status_d = uks_pkg::ST_DUP;
					state_d      = S_DONE;
				end else if (CNT_W'(idx_q) == last_idx) begin
					if (is_full) begin
						res_status_d = uks_pkg::ST_FULL;
					end else begin
						mem_wr_en = 1'b1;
						fill_d    = fill_q + 1'b1;
					end
					state_d = S_DONE;
				end else begin
					mem_rd_addr = ADDR_W'(idx_q + 1'b1);
					idx_d       = ADDR_W'(idx_q + 1'b1);
				end
			end
			S_TOP: begin
				res_pair_d = mem_rd_data;
				if (cmd_q == uks_pkg::CMD_POP) begin
					fill_d = last_idx;
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q        <= idx_d;
		res_status_q <= res_status_d;
		res_pair_q   <= res_pair_d;
		if (accept) begin
			cmd_q   <= req.cmd;
			key_q   <= req.push_key;
			value_q <= req.push_value;
		end
		if (state_q == S_DONE && out_free) begin
			rsp_status_q <= res_status_q;
			rsp_pair_q   <= res_pair_q;
			rsp_count_q  <= uks_pkg::COUNT_W'(fill_q);
			rsp_empty_q  <= (fill_q == '0);
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.top_key     = rsp_pair_q.key;
	assign rsp.top_value   = rsp_pair_q.value;
	assign rsp.entry_count = rsp_count_q;
	assign rsp.is_empty    = rsp_empty_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(STACK_DEPTH))
		else $error("fill level beyond depth");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr_en |-> !is_full && cmd_q == uks_pkg::CMD_PUSH)
		else $error("store written while full or not pushing");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_status_q == uks_pkg::ST_EMPTY |-> rsp_empty_q)
		else $error("empty status with entries held");

	a_fill_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TOP && cmd_q == uks_pkg::CMD_POP |=> fill_q == $past(fill_q) - 1'b1)
		else $error("pop did not drop fill level");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !req.ready)
		else $error("second beat taken while busy");

endmodule
`default_nettype wire

FILE: design/unique_key_stack.sv
`default_nettype none
// Push onto an empty stack, pop/peek of an empty stack or an unused command go
// straight to the response; pop or peek first reads the top pair from the store;
// a push compares stored keys one per cycle (up to STACK_DEPTH), stopping at the
// first duplicate. A command is taken only once the last response is registered;
// a response still waiting downstream holds the block busy until it goes.
// Reset (arst_n, async, active low) empties the stack; store contents are not cleared.
// ----------------------------------------------------------------------------
// unique_key_stack
// LIFO stack of key/data pairs that refuses a push whose key is already held;
// push, pop and peek report status, the top pair, the entry count and an
// empty flag.
// ----------------------------------------------------------------------------
module unique_key_stack #(
	parameter int unsigned STACK_DEPTH = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	uks_req_if.sink    req,
	uks_rsp_if.source  rsp
);

	localparam int unsigned ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);

	logic              mem_wr_en;
	logic [ADDR_W-1:0] mem_wr_addr;
	uks_pkg::entry_t   mem_wr_data;
	logic [ADDR_W-1:0] mem_rd_addr;
	uks_pkg::entry_t   mem_rd_data;

	uks_seq #(
		.STACK_DEPTH (STACK_DEPTH),
		.ADDR_W      (ADDR_W),
		.CNT_W       (CNT_W)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data)
	);

	uks_store #(
		.STACK_DEPTH (STACK_DEPTH),
		.ADDR_W      (ADDR_W)
	) u_store (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

endmodule
`default_nettype wire
